[hdl/mlrq_pkg.sv]
// shared constants, types and helper functions of the ready queue scheduler
package mlrq_pkg;

   localparam int NUM_CPUS    = 4;
   localparam int NUM_LEVELS  = 8;
   localparam int QUEUE_DEPTH = 16;
   localparam int TID_W       = 8;

   localparam int CPU_W   = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
   localparam int LVL_W   = $clog2(NUM_LEVELS);
   localparam int NQ      = NUM_CPUS * NUM_LEVELS;
   localparam int Q_W     = $clog2(NQ);
   localparam int PTR_W   = $clog2(QUEUE_DEPTH);
   localparam int FILL_W  = $clog2(QUEUE_DEPTH + 1);
   localparam int SLOTS   = NQ * QUEUE_DEPTH;
   localparam int ADDR_W  = $clog2(SLOTS);
   localparam int LOAD_W  = 16;
   localparam int CNT_W   = 8;
   localparam int BASE_W  = 8;
   localparam int REM_W   = 16;
   localparam int DEP_W   = 8;
   localparam int GRANT_W = 15;
   localparam int WDATA_W = 8;
   localparam int SH_W    = BASE_W + NUM_LEVELS - 1;

   localparam logic [BASE_W-1:0]   TSLICE_RESET = 8'd10;
   localparam logic [NUM_CPUS-1:0] ACTIVE_RESET = NUM_CPUS'(1);

   localparam logic [1:0] OP_PUSH = 2'd0;
   localparam logic [1:0] OP_POP  = 2'd1;
   localparam logic [1:0] OP_XCHG = 2'd2;

   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_DEFER = 2'd1;
   localparam logic [1:0] STAT_FULL  = 2'd2;
   localparam logic [1:0] STAT_EMPTY = 2'd3;

   localparam logic REG_TSLICE = 1'b0;
   localparam logic REG_ACTIVE = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PUSH,
      ST_XCHG,
      ST_SCAN,
      ST_STEAL,
      ST_READ
   } state_type;

   // cpu number of a 2-bit request field, wrapped into range
   function automatic logic [CPU_W-1:0] cpu_of(input logic [1:0] v);
      int t;
      t = int'(v);
      for (int k = 0; k < 3; k++) begin
         if (t >= NUM_CPUS) begin
            t = t - NUM_CPUS;
         end
      end
      return CPU_W'(t);
   endfunction

   function automatic logic [GRANT_W-1:0] grant(input logic [LVL_W-1:0] lvl,
                                                input logic [BASE_W-1:0] base);
      logic [SH_W-1:0] sh;
      sh = SH_W'(base) << lvl;
      if (int'(sh) > 32'h7FFF) begin
         return GRANT_W'(32'h7FFF);
      end
      return GRANT_W'(sh);
   endfunction

   function automatic logic [LVL_W-1:0] adjust_pri(input logic [LVL_W-1:0] pri,
                                                    input logic fixed,
                                                    input logic signed [REM_W-1:0] rem,
                                                    input logic [BASE_W-1:0] base);
      logic [SH_W-1:0] sh;
      int half_i;
      int rem_i;
      sh = SH_W'(base) << pri;
      half_i = int'(sh >> 1);
      rem_i = int'(rem);
      if (fixed || (rem_i > 0 && rem_i < half_i)) begin
         return pri;
      end
      if (rem_i < 1) begin
         return (int'(pri) < NUM_LEVELS - 1) ? pri + LVL_W'(1) : pri;
      end
      return (int'(pri) > 1) ? pri - LVL_W'(1) : pri;
   endfunction

endpackage

[hdl/multilevel_ready_queue_scheduler_core.sv]
// Multilevel ready queue scheduler: per-cpu fifos of thread ids in a ram, one per level.
// A transaction is taken when start is high and busy is low; its single result shows for
// one cycle with rsp_valid and cannot be stalled. A push is answered from its push state.
// A pop walks the levels of the requesting cpu one per cycle; with no local thread and two
// or more active cpus a steal state picks the busiest other cpu with a queued thread and a
// second walk follows. An exchange enqueues in its own state before the walk. The walk runs
// over the head and fill table, and the thread id is read from a ram with registered read.
// Configuration writes take effect at once and should only be made while idle.
module multilevel_ready_queue_scheduler_core
   import mlrq_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic [1:0]               req_op,
   input  logic [1:0]               req_requester_cpu,
   input  logic [TID_W-1:0]         req_thread_id,
   input  logic [2:0]               req_cur_priority,
   input  logic                     req_fixed_priority,
   input  logic signed [REM_W-1:0]  req_remaining_ticks,
   input  logic [1:0]               req_affinity_cpu,
   input  logic [DEP_W-1:0]         req_entry_signal_depth,
   input  logic [DEP_W-1:0]         req_thread_signal_depth,
   input  logic                     req_to_front,
   output logic                     rsp_valid,
   output logic [1:0]               rsp_status,
   output logic                     rsp_thread_valid,
   output logic [TID_W-1:0]         rsp_out_thread_id,
   output logic [2:0]               rsp_out_priority,
   output logic [GRANT_W-1:0]       rsp_granted_ticks,
   output logic [2:0]               rsp_new_priority,
   output logic [1:0]               rsp_new_affinity,
   output logic                     rsp_ipi_needed,
   output logic [1:0]               rsp_ipi_target,
   input  logic                     csr_we,
   input  logic                     csr_index,
   input  logic [WDATA_W-1:0]       csr_wdata
);

   state_type state_ff, state_in;

   logic [1:0]              op_ff, op_in;
   logic [CPU_W-1:0]        req_ff, req_in;
   logic [CPU_W-1:0]        aff_ff, aff_in;
   logic [TID_W-1:0]        id_ff, id_in;
   logic [LVL_W-1:0]        cur_ff, cur_in;
   logic                    fixed_ff, fixed_in;
   logic signed [REM_W-1:0] rem_ff, rem_in;
   logic [DEP_W-1:0]        edep_ff, edep_in;
   logic [DEP_W-1:0]        tdep_ff, tdep_in;
   logic                    front_ff, front_in;

   logic [CPU_W-1:0] scan_cpu_ff, scan_cpu_in;
   logic [LVL_W-1:0] scan_lvl_ff, scan_lvl_in;
   logic [LVL_W-1:0] got_lvl_ff, got_lvl_in;
   logic [LVL_W-1:0] xpri_ff, xpri_in;
   logic             steal_ff, steal_in;
   logic             xok_ff, xok_in;

   logic [PTR_W-1:0]  head_ff [NQ];
   logic [PTR_W-1:0]  head_in [NQ];
   logic [FILL_W-1:0] fill_ff [NQ];
   logic [FILL_W-1:0] fill_in [NQ];
   logic [LOAD_W-1:0] load_ff [NUM_CPUS];
   logic [LOAD_W-1:0] load_in [NUM_CPUS];
   logic [CNT_W-1:0]  cnt_ff [NUM_CPUS];
   logic [CNT_W-1:0]  cnt_in [NUM_CPUS];

   logic [BASE_W-1:0]   tslice_ff, tslice_in;
   logic [NUM_CPUS-1:0] active_ff, active_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [1:0]         rsp_status_ff, rsp_status_in;
   logic               rsp_tvalid_ff, rsp_tvalid_in;
   logic [TID_W-1:0]   rsp_tid_ff, rsp_tid_in;
   logic [2:0]         rsp_opri_ff, rsp_opri_in;
   logic [GRANT_W-1:0] rsp_grant_ff, rsp_grant_in;
   logic [2:0]         rsp_npri_ff, rsp_npri_in;
   logic [1:0]         rsp_naff_ff, rsp_naff_in;
   logic               rsp_ipi_ff, rsp_ipi_in;
   logic [1:0]         rsp_ipit_ff, rsp_ipit_in;

   // helpers
   logic [LVL_W-1:0]  push_pri;
   logic [LVL_W-1:0]  enq_pri;
   logic              enq_front;
   logic [CPU_W-1:0]  push_tgt;
   logic              tgt_done;
   logic [Q_W-1:0]    q_sel;
   logic [PTR_W-1:0]  hd;
   logic [FILL_W-1:0] fl;
   logic [PTR_W-1:0]  hd_dec;
   logic [PTR_W-1:0]  hd_inc;
   logic [FILL_W:0]   back_sum;
   logic [PTR_W-1:0]  back_pos;
   logic [PTR_W-1:0]  enq_pos;
   logic [PTR_W-1:0]  enq_head;
   logic              q_full;
   logic              scan_hit;
   logic              scan_last;
   logic              few_active;
   logic              steal_found;
   logic [CPU_W-1:0]  steal_best;
   logic [LOAD_W-1:0] steal_load;
   logic [LOAD_W-1:0] steal_w;

   logic              ram_we;
   logic [ADDR_W-1:0] ram_waddr;
   logic [TID_W-1:0]  ram_wdata;
   logic [ADDR_W-1:0] ram_raddr;
   logic [TID_W-1:0]  ram_rdata;

   mlrq_ram #(
      .WIDTH(TID_W),
      .DEPTH(SLOTS)
   ) u_store (
      .clock(clock),
      .we   (ram_we),
      .waddr(ram_waddr),
      .wdata(ram_wdata),
      .raddr(ram_raddr),
      .rdata(ram_rdata)
   );

   // queue selection and enqueue position
   always_comb begin
      push_pri  = adjust_pri(cur_ff, fixed_ff, rem_ff, tslice_ff);
      enq_front = (state_ff == ST_XCHG) && front_ff;
      enq_pri   = enq_front ? cur_ff : push_pri;

      // loaded cpu hands the thread to the first active idle one
      push_tgt = aff_ff;
      tgt_done = 1'b0;
      if (load_ff[aff_ff] != '0) begin
         for (int i = 0; i < NUM_CPUS; i++) begin
            if (!tgt_done && active_ff[i] && load_ff[i] == '0) begin
               push_tgt = CPU_W'(i);
               tgt_done = 1'b1;
            end
         end
      end

      case (state_ff)
         ST_PUSH: q_sel = Q_W'(int'(push_tgt) * NUM_LEVELS + int'(push_pri));
         ST_XCHG: q_sel = Q_W'(int'(req_ff) * NUM_LEVELS + int'(enq_pri));
         default: q_sel = Q_W'(int'(scan_cpu_ff) * NUM_LEVELS + int'(scan_lvl_ff));
      endcase

      hd       = head_ff[q_sel];
      fl       = fill_ff[q_sel];
      hd_dec   = (hd == '0) ? PTR_W'(QUEUE_DEPTH - 1) : hd - PTR_W'(1);
      hd_inc   = (int'(hd) == QUEUE_DEPTH - 1) ? '0 : hd + PTR_W'(1);
      back_sum = (FILL_W + 1)'(hd) + (FILL_W + 1)'(fl);
      back_pos = (int'(back_sum) >= QUEUE_DEPTH) ? PTR_W'(int'(back_sum) - QUEUE_DEPTH)
                                                 : PTR_W'(back_sum);
      enq_pos  = enq_front ? hd_dec : back_pos;
      enq_head = enq_front ? hd_dec : hd;
      q_full   = int'(fl) >= QUEUE_DEPTH;

      scan_hit   = fl != '0;
      scan_last  = int'(scan_lvl_ff) == NUM_LEVELS - 1;
      few_active = $countones(active_ff) < 2;

      // busiest other cpu with a queued thread
      steal_found = 1'b0;
      steal_best  = '0;
      steal_load  = '0;
      for (int i = 0; i < NUM_CPUS; i++) begin
         if (CPU_W'(i) != req_ff && cnt_ff[i] != '0 && load_ff[i] > steal_load) begin
            steal_found = 1'b1;
            steal_best  = CPU_W'(i);
            steal_load  = load_ff[i];
         end
      end
      steal_w = LOAD_W'(NUM_LEVELS - int'(got_lvl_ff));
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               case (req_op)
                  OP_PUSH: state_in = ST_PUSH;
                  OP_POP:  state_in = ST_SCAN;
                  OP_XCHG: state_in = ST_XCHG;
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_PUSH: state_in = ST_IDLE;
         ST_XCHG: state_in = ST_SCAN;
         ST_SCAN: begin
            if (scan_hit) begin
               state_in = ST_READ;
            end else if (scan_last) begin
               if (op_ff == OP_POP && !steal_ff && !few_active) begin
                  state_in = ST_STEAL;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_STEAL: state_in = steal_found ? ST_SCAN : ST_IDLE;
         ST_READ:  state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // datapath and result
   always_comb begin
      op_in       = op_ff;
      req_in      = req_ff;
      aff_in      = aff_ff;
      id_in       = id_ff;
      cur_in      = cur_ff;
      fixed_in    = fixed_ff;
      rem_in      = rem_ff;
      edep_in     = edep_ff;
      tdep_in     = tdep_ff;
      front_in    = front_ff;
      scan_cpu_in = scan_cpu_ff;
      scan_lvl_in = scan_lvl_ff;
      got_lvl_in  = got_lvl_ff;
      xpri_in     = xpri_ff;
      steal_in    = steal_ff;
      xok_in      = xok_ff;
      head_in     = head_ff;
      fill_in     = fill_ff;
      load_in     = load_ff;
      cnt_in      = cnt_ff;
      tslice_in   = tslice_ff;
      active_in   = active_ff;

      ram_we    = 1'b0;
      ram_waddr = ADDR_W'(int'(q_sel) * QUEUE_DEPTH + int'(enq_pos));
      ram_wdata = id_ff;
      ram_raddr = ADDR_W'(int'(q_sel) * QUEUE_DEPTH + int'(hd));

      rsp_valid_in  = 1'b0;
      rsp_status_in = STAT_OK;
      rsp_tvalid_in = 1'b0;
      rsp_tid_in    = '0;
      rsp_opri_in   = '0;
      rsp_grant_in  = '0;
      rsp_npri_in   = '0;
      rsp_naff_in   = '0;
      rsp_ipi_in    = 1'b0;
      rsp_ipit_in   = '0;

      if (csr_we) begin
         case (csr_index)
            REG_TSLICE: tslice_in = csr_wdata[BASE_W-1:0];
            REG_ACTIVE: active_in = NUM_CPUS'(csr_wdata);
            default:    ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               op_in       = req_op;
               req_in      = cpu_of(req_requester_cpu);
               aff_in      = cpu_of(req_affinity_cpu);
               id_in       = req_thread_id;
               cur_in      = (int'(req_cur_priority) > NUM_LEVELS - 1)
                             ? LVL_W'(NUM_LEVELS - 1) : LVL_W'(req_cur_priority);
               fixed_in    = req_fixed_priority;
               rem_in      = req_remaining_ticks;
               edep_in     = req_entry_signal_depth;
               tdep_in     = req_thread_signal_depth;
               front_in    = req_to_front;
               scan_cpu_in = cpu_of(req_requester_cpu);
               scan_lvl_in = '0;
               steal_in    = 1'b0;
               if (req_op != OP_PUSH && req_op != OP_POP && req_op != OP_XCHG) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = STAT_EMPTY;
               end
            end
         end
         ST_PUSH: begin
            rsp_valid_in = 1'b1;
            if (edep_ff < tdep_ff) begin
               rsp_status_in = STAT_DEFER;
            end else begin
               rsp_npri_in = 3'(push_pri);
               rsp_naff_in = 2'(push_tgt);
               if (q_full) begin
                  rsp_status_in = STAT_FULL;
               end else begin
                  ram_we            = 1'b1;
                  fill_in[q_sel]    = fl + FILL_W'(1);
                  load_in[push_tgt] = load_ff[push_tgt] + LOAD_W'(NUM_LEVELS - int'(push_pri));
                  cnt_in[push_tgt]  = cnt_ff[push_tgt] + CNT_W'(1);
                  if (push_tgt != req_ff) begin
                     rsp_ipi_in  = 1'b1;
                     rsp_ipit_in = 2'(push_tgt);
                  end
               end
            end
         end
         ST_XCHG: begin
            xpri_in     = enq_pri;
            xok_in      = !q_full;
            scan_cpu_in = req_ff;
            scan_lvl_in = '0;
            steal_in    = 1'b0;
            if (!q_full) begin
               ram_we         = 1'b1;
               head_in[q_sel] = enq_head;
               fill_in[q_sel] = fl + FILL_W'(1);
               cnt_in[req_ff] = cnt_ff[req_ff] + CNT_W'(1);
               if (!front_ff) begin
                  load_in[req_ff] = load_ff[req_ff] + LOAD_W'(cur_ff) - LOAD_W'(enq_pri);
               end
            end
         end
         ST_SCAN: begin
            if (scan_hit) begin
               head_in[q_sel]      = hd_inc;
               fill_in[q_sel]      = fl - FILL_W'(1);
               cnt_in[scan_cpu_ff] = cnt_ff[scan_cpu_ff] - CNT_W'(1);
               got_lvl_in          = scan_lvl_ff;
            end else if (scan_last) begin
               if (op_ff == OP_XCHG) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = xok_ff ? STAT_EMPTY : STAT_FULL;
                  rsp_npri_in   = 3'(xpri_ff);
                  rsp_naff_in   = 2'(req_ff);
               end else if (steal_ff || few_active) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = STAT_EMPTY;
               end
            end else begin
               scan_lvl_in = scan_lvl_ff + LVL_W'(1);
            end
         end
         ST_STEAL: begin
            if (steal_found) begin
               scan_cpu_in = steal_best;
               scan_lvl_in = '0;
               steal_in    = 1'b1;
            end else begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STAT_EMPTY;
            end
         end
         ST_READ: begin
            rsp_valid_in  = 1'b1;
            rsp_tvalid_in = 1'b1;
            rsp_tid_in    = ram_rdata;
            rsp_opri_in   = 3'(got_lvl_ff);
            rsp_grant_in  = grant(got_lvl_ff, tslice_ff);
            rsp_naff_in   = 2'(req_ff);
            if (op_ff == OP_XCHG) begin
               rsp_status_in = xok_ff ? STAT_OK : STAT_FULL;
               rsp_npri_in   = 3'(xpri_ff);
            end else if (steal_ff) begin
               // stolen thread carries its load weight over to the requester
               load_in[scan_cpu_ff] = load_ff[scan_cpu_ff] - steal_w;
               load_in[req_ff]      = load_ff[req_ff] + steal_w;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         tslice_ff    <= TSLICE_RESET;
         active_ff    <= ACTIVE_RESET;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NQ; i++) begin
            head_ff[i] <= '0;
            fill_ff[i] <= '0;
         end
         for (int i = 0; i < NUM_CPUS; i++) begin
            load_ff[i] <= '0;
            cnt_ff[i]  <= '0;
         end
      end else begin
         state_ff     <= state_in;
         tslice_ff    <= tslice_in;
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
         head_ff      <= head_in;
         fill_ff      <= fill_in;
         load_ff      <= load_in;
         cnt_ff       <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      req_ff        <= req_in;
      aff_ff        <= aff_in;
      id_ff         <= id_in;
      cur_ff        <= cur_in;
      fixed_ff      <= fixed_in;
      rem_ff        <= rem_in;
      edep_ff       <= edep_in;
      tdep_ff       <= tdep_in;
      front_ff      <= front_in;
      scan_cpu_ff   <= scan_cpu_in;
      scan_lvl_ff   <= scan_lvl_in;
      got_lvl_ff    <= got_lvl_in;
      xpri_ff       <= xpri_in;
      steal_ff      <= steal_in;
      xok_ff        <= xok_in;
      rsp_status_ff <= rsp_status_in;
      rsp_tvalid_ff <= rsp_tvalid_in;
      rsp_tid_ff    <= rsp_tid_in;
      rsp_opri_ff   <= rsp_opri_in;
      rsp_grant_ff  <= rsp_grant_in;
      rsp_npri_ff   <= rsp_npri_in;
      rsp_naff_ff   <= rsp_naff_in;
      rsp_ipi_ff    <= rsp_ipi_in;
      rsp_ipit_ff   <= rsp_ipit_in;
   end

   assign busy              = state_ff != ST_IDLE;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_thread_valid  = rsp_tvalid_ff;
   assign rsp_out_thread_id = rsp_tid_ff;
   assign rsp_out_priority  = rsp_opri_ff;
   assign rsp_granted_ticks = rsp_grant_ff;
   assign rsp_new_priority  = rsp_npri_ff;
   assign rsp_new_affinity  = rsp_naff_ff;
   assign rsp_ipi_needed    = rsp_ipi_ff;
   assign rsp_ipi_target    = rsp_ipit_ff;

endmodule

[hdl/mlrq_ram.sv]
// generic single-port-write ram with registered read
module mlrq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

[hdl/mlrq_checker.sv]
// port-level checks of the scheduler core, bound to the top level
module mlrq_checker
   import mlrq_pkg::*;
(
   input logic                    clock,
   input logic                    reset,
   input logic                    start,
   input logic                    busy,
   input logic                    rsp_valid,
   input logic [1:0]              rsp_status,
   input logic                    rsp_thread_valid,
   input logic [2:0]              rsp_new_priority,
   input logic [1:0]              rsp_new_affinity,
   input logic                    rsp_ipi_needed,
   input logic [1:0]              rsp_ipi_target
);

   // every accepted transaction either keeps the core busy or answers at once
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy || rsp_valid)
      else $error("accepted transaction neither started work nor answered");

   a_idle_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !busy)
      else $error("core busy right after reset");

   a_thread_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_thread_valid |-> rsp_status == STAT_OK || rsp_status == STAT_FULL)
      else $error("thread handed back with a deferred or empty status");

   a_ipi_push_only: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ipi_needed |->
         !rsp_thread_valid && rsp_status == STAT_OK && rsp_ipi_target == rsp_new_affinity)
      else $error("reschedule interrupt outside a successful push");

   a_defer_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STAT_DEFER |->
         !rsp_thread_valid && rsp_new_priority == 3'd0 && rsp_new_affinity == 2'd0)
      else $error("deferred push carries result fields");

endmodule

bind multilevel_ready_queue_scheduler_core mlrq_checker u_mlrq_checker (.*);
